// File: design/ted_pkg.sv
package ted_pkg;

    // Sizing
    localparam int MAX_LEN    = 256;
    localparam int TOKEN_BITS = 32;
    localparam int TOKEN_W    = 32;
    localparam int KIND_W     = 2;
    localparam int DIST_W     = 9;
    localparam int LEN_W      = $clog2(MAX_LEN + 1);
    localparam int IDX_W      = $clog2(MAX_LEN);
    localparam int COST_W     = LEN_W;
    localparam int SAT_W      = (COST_W > DIST_W) ? COST_W : DIST_W;

    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_A    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_B    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DIST = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic append_a;
        logic append_b;
        logic dist_now;   // one sequence empty: answer straight away
        logic run_init;   // full compute begins at row zero
        logic row_start;
        logic cell_step;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic len_a_zero;
        logic len_b_zero;
        logic row_end;
        logic last_row;
        logic out_valid;
    } t_sts;

endpackage

// File: design/ted_ram.sv
module ted_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/ted_ctrl.sv
module ted_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic [ted_pkg::KIND_W-1:0]  i_kind,
    input  ted_pkg::t_sts               i_sts,
    output logic                        o_in_stall,
    output ted_pkg::t_cmd               o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_ROW  = 2'd1;
    localparam logic [1:0] S_CELL = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       w_accept;
    logic       w_empty;

    // Input side: busy while computing, or a distance would collide with a held result
    assign o_in_stall = (r_state != S_IDLE) || ((i_kind == ted_pkg::KIND_DIST) && i_sts.out_valid);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_empty    = i_sts.len_a_zero || i_sts.len_b_zero;

    // Commands
    always_comb begin
        o_cmd           = '0;
        o_cmd.append_a  = w_accept && (i_kind == ted_pkg::KIND_A);
        o_cmd.append_b  = w_accept && (i_kind == ted_pkg::KIND_B);
        o_cmd.dist_now  = w_accept && (i_kind == ted_pkg::KIND_DIST) && w_empty;
        o_cmd.run_init  = w_accept && (i_kind == ted_pkg::KIND_DIST) && !w_empty;
        o_cmd.row_start = (r_state == S_ROW);
        o_cmd.cell_step = (r_state == S_CELL);
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (o_cmd.run_init) begin
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                n_state = S_CELL;
            end
            S_CELL: begin
                if (i_sts.row_end) begin
                    n_state = i_sts.last_row ? S_IDLE : S_ROW;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Row setup always hands over to the cell walk
    a_row_to_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROW) |=> (r_state == S_CELL))
        else $error("row setup not followed by cell walk");

    // Finishing the last cell produces a result and frees the block
    a_done_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_CELL) && i_sts.row_end && i_sts.last_row)
        |=> ((r_state == S_IDLE) && i_sts.out_valid))
        else $error("compute finished without result");

endmodule

// File: design/ted_dp.sv
module ted_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  ted_pkg::t_cmd                    i_cmd,
    input  logic [ted_pkg::TOKEN_W-1:0]      i_token,
    input  logic                             i_out_stall,
    output ted_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output logic [ted_pkg::DIST_W-1:0]       o_distance,
    output logic                             o_overflowed
);

    localparam int LW = ted_pkg::LEN_W;
    localparam int IW = ted_pkg::IDX_W;
    localparam int CW = ted_pkg::COST_W;
    localparam int TB = ted_pkg::TOKEN_BITS;

    logic [LW-1:0] r_len_a;
    logic [LW-1:0] r_len_b;
    logic          r_ovf;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_j;
    logic [CW-1:0] r_left;
    logic [CW-1:0] r_diag;
    logic          r_first_row;
    logic          r_out_valid;
    logic [CW-1:0] r_out_dist;
    logic          r_out_ovf;

    logic          w_full_a;
    logic          w_full_b;
    logic          w_wr_a;
    logic          w_wr_b;
    logic          w_done;
    logic [IW-1:0] w_rd_addr;
    logic          w_rd_b;
    logic [TB-1:0] w_a_tok;
    logic [TB-1:0] w_b_tok;
    logic [CW-1:0] w_cost_rd;
    logic [CW-1:0] w_up;
    logic [CW-1:0] w_min_lu;
    logic [CW-1:0] w_min;
    logic [CW-1:0] w_new;
    logic          w_sat;

    assign w_full_a = (r_len_a == LW'(ted_pkg::MAX_LEN));
    assign w_full_b = (r_len_b == LW'(ted_pkg::MAX_LEN));
    assign w_wr_a   = i_cmd.append_a && !w_full_a;
    assign w_wr_b   = i_cmd.append_b && !w_full_b;

    // Column read address: zero at row setup, next column during the walk
    assign w_rd_addr = i_cmd.row_start ? '0 : (r_j + IW'(1));
    assign w_rd_b    = i_cmd.row_start || i_cmd.cell_step;

    // Token and cost stores
    ted_ram #(.WIDTH(TB), .DEPTH(ted_pkg::MAX_LEN)) u_seq_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_a),
        .i_wr_addr (r_len_a[IW-1:0]),
        .i_wr_data (i_token[TB-1:0]),
        .i_rd_en   (i_cmd.row_start),
        .i_rd_addr (r_i),
        .o_rd_data (w_a_tok)
    );

    ted_ram #(.WIDTH(TB), .DEPTH(ted_pkg::MAX_LEN)) u_seq_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_b),
        .i_wr_addr (r_len_b[IW-1:0]),
        .i_wr_data (i_token[TB-1:0]),
        .i_rd_en   (w_rd_b),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_b_tok)
    );

    // Entry j holds the row cost for column j+1
    ted_ram #(.WIDTH(CW), .DEPTH(ted_pkg::MAX_LEN)) u_cost (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.cell_step),
        .i_wr_addr (r_j),
        .i_wr_data (w_new),
        .i_rd_en   (w_rd_b),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_cost_rd)
    );

    // One DP cell: the first row uses the implicit 0..len_b initial row
    always_comb begin
        w_up     = r_first_row ? (CW'(r_j) + CW'(1)) : w_cost_rd;
        w_min_lu = (r_left < w_up) ? r_left : w_up;
        w_min    = (w_min_lu < r_diag) ? w_min_lu : r_diag;
        w_new    = (w_a_tok == w_b_tok) ? r_diag : (w_min + CW'(1));
    end

    // Status
    assign o_sts.len_a_zero = (r_len_a == '0);
    assign o_sts.len_b_zero = (r_len_b == '0);
    assign o_sts.row_end    = ((LW'(r_j) + LW'(1)) == r_len_b);
    assign o_sts.last_row   = ((LW'(r_i) + LW'(1)) == r_len_a);
    assign o_sts.out_valid  = r_out_valid;

    assign w_done = i_cmd.cell_step && o_sts.row_end && o_sts.last_row;

    // Lengths, overflow flag and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_a     <= '0;
            r_len_b     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wr_a) begin
                r_len_a <= r_len_a + LW'(1);
            end
            if (w_wr_b) begin
                r_len_b <= r_len_b + LW'(1);
            end
            if ((i_cmd.append_a && w_full_a) || (i_cmd.append_b && w_full_b)) begin
                r_ovf <= 1'b1;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.dist_now || w_done) begin
                r_len_a     <= '0;
                r_len_b     <= '0;
                r_ovf       <= 1'b0;
                r_out_valid <= 1'b1;
            end
        end
    end

    // Walk counters and cell registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.run_init) begin
            r_i         <= '0;
            r_first_row <= 1'b1;
        end
        if (i_cmd.row_start) begin
            r_j    <= '0;
            r_left <= CW'(r_i) + CW'(1);
            r_diag <= CW'(r_i);
        end
        if (i_cmd.cell_step) begin
            r_j    <= r_j + IW'(1);
            r_left <= w_new;
            r_diag <= w_up;
            if (o_sts.row_end) begin
                r_i         <= r_i + IW'(1);
                r_first_row <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.dist_now) begin
            r_out_dist <= o_sts.len_a_zero ? CW'(r_len_b) : CW'(r_len_a);
            r_out_ovf  <= r_ovf;
        end else if (w_done) begin
            r_out_dist <= w_new;
            r_out_ovf  <= r_ovf;
        end
    end

    assign w_sat        = (ted_pkg::SAT_W'(r_out_dist) > ted_pkg::SAT_W'(ted_pkg::DIST_MAX));
    assign o_out_valid  = r_out_valid;
    assign o_distance   = w_sat ? ted_pkg::DIST_MAX : ted_pkg::DIST_W'(r_out_dist);
    assign o_overflowed = r_out_ovf;

    // Cost store never reads the entry it writes in the same cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cell_step |-> (w_rd_addr != r_j))
        else $error("cost store read/write address clash");

    // Lengths stay within capacity
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_len_a <= LW'(ted_pkg::MAX_LEN)) && (r_len_b <= LW'(ted_pkg::MAX_LEN)))
        else $error("sequence length out of range");

    // A result clears both sequences and the overflow flag
    a_clear_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.dist_now || w_done) |=> ((r_len_a == '0) && (r_len_b == '0) && !r_ovf))
        else $error("state not cleared after result");

endmodule

// File: design/token_edit_distance_unit.sv
// A distance transaction gives its result in the cycle after acceptance when either
// sequence is empty, else once the full DP walk over all rows of A has finished.
// Throughput: one append per cycle while no compute runs; the compute walks one DP cell
// per cycle through the cost-row memory, plus a row setup step per row of A for its token.
// Reset (synchronous, active low): both sequences empty, overflow clear, no result held.
module token_edit_distance_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [ted_pkg::KIND_W-1:0]     i_kind,
    input  logic [ted_pkg::TOKEN_W-1:0]    i_token,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [ted_pkg::DIST_W-1:0]     o_distance,
    output logic                           o_overflowed
);

    ted_pkg::t_cmd w_cmd;
    ted_pkg::t_sts w_sts;

    // Sequencer
    ted_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_kind     (i_kind),
        .i_sts      (w_sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Stores, DP cell and result register
    ted_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_token      (i_token),
        .i_out_stall  (i_out_stall),
        .o_sts        (w_sts),
        .o_out_valid  (o_out_valid),
        .o_distance   (o_distance),
        .o_overflowed (o_overflowed)
    );

endmodule
